// ===== rtl/stbs_pkg.sv =====
package stbs_pkg;

    // Field widths of the request and result items
    localparam int CMD_W  = 1;
    localparam int IDX_W  = 10;
    localparam int KEY_W  = 32;
    localparam int LEN_W  = 11;

    // Packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((IDX_W + 2 * KEY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((IDX_W + 7) / 8) * 8;

    // Default table size
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // Request kinds
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

endpackage

// ===== rtl/sorted_table_binary_search.sv =====
// Sorted table with three-way binary search over one synchronous RAM.
// Load: writes one entry, gives no result.
// Search: one RAM read per probe; the result is registered after the last probe,
// or held in S_WAIT while the receiver stalls. An empty table gives a miss
// without a probe. One request at a time.
// Reset (aresetn low, synchronous) clears control state and table_length; entries are not cleared.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: table_length
    input  logic                            cfg_wen,
    input  logic [stbs_pkg::LEN_W-1:0]      cfg_wdata,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: entry_index [9:0], entry_value [41:10], search_key [73:42], zero pad
    input  logic [stbs_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: command
    input  logic [stbs_pkg::CMD_W-1:0]      s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: position [9:0], zero pad
    output logic [stbs_pkg::M_TDATA_W-1:0]  m_tdata,
    // tuser: found
    output logic                            m_tuser
);
    import stbs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int MW = (CW > LEN_W) ? CW : LEN_W;
    localparam int XW = AW + IDX_W;
    localparam int PW = CW + IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_WAIT
    } state_t;

    // Table storage and read data register
    logic signed [KEY_W-1:0] mem [TABLE_DEPTH];
    logic signed [KEY_W-1:0] rd_data_reg;

    state_t                  state_reg, state_next;
    logic [LEN_W-1:0]        len_reg;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hi_reg, hi_next;
    logic [CW-1:0]           mid_reg, mid_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic                    m_found_reg, m_found_next;
    logic [IDX_W-1:0]        m_pos_reg, m_pos_next;
    logic                    pend_found_reg, pend_found_next;
    logic [IDX_W-1:0]        pend_pos_reg, pend_pos_next;

    // Unpack the request
    cmd_t                    in_cmd;
    logic [IDX_W-1:0]        in_idx;
    logic signed [KEY_W-1:0] in_value;
    logic signed [KEY_W-1:0] in_key;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_value = s_tdata[IDX_W +: KEY_W];
    assign in_key   = s_tdata[IDX_W + KEY_W +: KEY_W];

    logic s_accept;
    logic out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Clamp the table length to the table depth
    logic [MW-1:0] len_ext;
    logic [MW-1:0] len_clamped;
    logic [CW-1:0] n_len;

    assign len_ext     = MW'(len_reg);
    assign len_clamped = (len_ext > MW'(TABLE_DEPTH)) ? MW'(TABLE_DEPTH) : len_ext;
    assign n_len       = len_clamped[CW-1:0];

    // Load write port
    logic [XW-1:0] wr_idx_ext;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    assign wr_idx_ext = XW'(in_idx);
    assign wr_addr    = wr_idx_ext[AW-1:0];
    assign wr_en      = s_accept && (in_cmd == CMD_LOAD) && (int'(in_idx) < TABLE_DEPTH);

    // Probe logic
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     cand_lo, cand_hi;
    logic [CW:0]       mid_sum;
    logic [CW-1:0]     cand_mid;
    logic              fin_valid, fin_found;
    logic [CW-1:0]     fin_mid;
    logic [PW-1:0]     fin_pos_ext;
    logic [IDX_W-1:0]  fin_pos;

    always_comb begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        key_next        = key_reg;
        pend_found_next = pend_found_reg;
        pend_pos_next   = pend_pos_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_found_next    = m_found_reg;
        m_pos_next      = m_pos_reg;
        rd_en           = 1'b0;
        fin_valid       = 1'b0;
        fin_found       = 1'b0;
        fin_mid         = '0;
        cand_lo         = '0;
        cand_hi         = n_len;

        // Narrow the bounds from the probed entry
        if (state_reg == S_SEARCH) begin
            cand_lo = lo_reg;
            cand_hi = hi_reg;
            if (key_reg < rd_data_reg) begin
                cand_hi = mid_reg;
            end else if (key_reg > rd_data_reg) begin
                cand_lo = mid_reg + CW'(1);
            end
        end

        // Midpoint of [lo, hi - 1]
        mid_sum  = (CW + 1)'(cand_lo) + (CW + 1)'(cand_hi) - (CW + 1)'(1);
        cand_mid = mid_sum[CW:1];
        rd_addr  = cand_mid[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_accept && in_cmd == CMD_SEARCH) begin
                    key_next = in_key;
                    lo_next  = cand_lo;
                    hi_next  = cand_hi;
                    if (n_len == '0) begin
                        fin_valid = 1'b1;
                    end else begin
                        mid_next   = cand_mid;
                        rd_en      = 1'b1;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (key_reg == rd_data_reg) begin
                    fin_valid = 1'b1;
                    fin_found = 1'b1;
                    fin_mid   = mid_reg;
                end else if (cand_lo >= cand_hi) begin
                    fin_valid = 1'b1;
                end else begin
                    lo_next  = cand_lo;
                    hi_next  = cand_hi;
                    mid_next = cand_mid;
                    rd_en    = 1'b1;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = pend_found_reg;
                    m_pos_next    = pend_pos_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        fin_pos_ext = PW'(fin_mid);
        fin_pos     = fin_pos_ext[IDX_W-1:0];

        // Deliver the result, or hold it until the output frees up
        if (fin_valid) begin
            if (out_free) begin
                m_tvalid_next = 1'b1;
                m_found_next  = fin_found;
                m_pos_next    = fin_pos;
                state_next    = S_IDLE;
            end else begin
                pend_found_next = fin_found;
                pend_pos_next   = fin_pos;
                state_next      = S_WAIT;
            end
        end
    end

    // Table RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // State, bounds and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wen) begin
                len_reg <= cfg_wdata;
            end
        end
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        key_reg        <= key_next;
        pend_found_reg <= pend_found_next;
        pend_pos_reg   <= pend_pos_next;
        m_found_reg    <= m_found_next;
        m_pos_reg      <= m_pos_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = M_TDATA_W'(m_pos_reg);

endmodule

// ===== dv/tb_sorted_table_binary_search.sv =====
`timescale 1ns / 1ps

module tb_sorted_table_binary_search;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int S_PAD_W = S_TDATA_W - IDX_W - 2 * KEY_W;
    localparam int M_PAD_W = M_TDATA_W - IDX_W;
    // Slowest step: a long request gap, a full search and a long receiver stall;
    // a quiet stretch well past all of these means the block is stuck.
    localparam int WATCHDOG_LIMIT = 4000;
    // Longest search is 11 probes, and its result is then registered.
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } lookup_result_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wen = 1'b0;
    logic [LEN_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // tdata: entry_index [9:0], entry_value [41:10], search_key [73:42], zero pad
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    // tuser: command
    logic [CMD_W-1:0]      s_tuser = CMD_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // tdata: position [9:0], zero pad
    logic [M_TDATA_W-1:0]  m_tdata;
    // tuser: found
    logic                  m_tuser;

    // Mirror of the block's table and length register
    logic signed [KEY_W-1:0] entry_mirror [TABLE_DEPTH];
    logic [LEN_W-1:0]        length_mirror = '0;
    lookup_result_t          pending_lookups [$];
    lookup_result_t          oldest_lookup;

    int error_count = 0;
    int loads_sent = 0;
    int searches_sent = 0;
    int results_checked = 0;
    int hits_seen = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_cycles = 0;
    int          pattern_step = 0;

    sorted_table_binary_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Three-way binary search over the mirrored table
    function automatic lookup_result_t predict_lookup(logic signed [KEY_W-1:0] key);
        int lo;
        int hi;
        int mid;
        int span;
        lookup_result_t r;
        r = '0;
        span = (int'(length_mirror) > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_mirror);
        lo = 0;
        hi = span - 1;
        while (lo <= hi && !r.found) begin
            mid = (lo + hi) / 2;
            if (key < entry_mirror[mid]) begin
                hi = mid - 1;
            end else if (key > entry_mirror[mid]) begin
                lo = mid + 1;
            end else begin
                r.found = 1'b1;
                r.position = mid[IDX_W-1:0];
            end
        end
        return r;
    endfunction

    // Keys held in the table, their neighbors, the extremes and arbitrary values
    function automatic logic signed [KEY_W-1:0] pick_probe_key(int span);
        int roll;
        int slot;
        roll = $urandom_range(0, 99);
        if (span > TABLE_DEPTH) span = TABLE_DEPTH;
        if (span == 0 || roll < 15) return $urandom;
        slot = $urandom_range(0, span - 1);
        if (roll < 60) return entry_mirror[slot];
        if (roll < 75) return entry_mirror[slot] + 1;
        if (roll < 90) return entry_mirror[slot] - 1;
        if (roll < 95) return 32'sh8000_0000;
        return 32'sh7fff_ffff;
    endfunction

    // Present one request in bursts with random gaps; update the mirror on accept
    task automatic send_request(cmd_t cmd, logic [IDX_W-1:0] idx,
                                logic signed [KEY_W-1:0] value,
                                logic signed [KEY_W-1:0] key);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 96)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{S_PAD_W{1'b0}}, key, value, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_LOAD) begin
            entry_mirror[idx] = value;
            loads_sent++;
        end else begin
            pending_lookups.push_back(predict_lookup(key));
            searches_sent++;
        end
    endtask

    task automatic load_entry(logic [IDX_W-1:0] idx, logic signed [KEY_W-1:0] value);
        send_request(CMD_LOAD, idx, value, $urandom);
    endtask

    task automatic search_for(logic signed [KEY_W-1:0] key);
        send_request(CMD_SEARCH, IDX_W'($urandom), $urandom, key);
    endtask

    // Drop valid, wait for every result, then let the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called while idle
    task automatic write_table_length(logic [LEN_W-1:0] len);
        cfg_wen   <= 1'b1;
        cfg_wdata <= len;
        @(posedge aclk);
        length_mirror = len;
        cfg_wen <= 1'b0;
    endtask

    // Load entries 0..count-1 in ascending order, with duplicates and extremes
    task automatic load_sorted_run(int count);
        longint v;
        int roll;
        v = ($urandom_range(0, 3) == 0) ? -64'sd2147483648 : longint'(int'($urandom)) / 2;
        for (int i = 0; i < count; i++) begin
            if (i > 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 25) v = v;
                else if (roll < 65) v = v + $urandom_range(1, 50);
                else v = v + $urandom_range(1, 32'h1000_0000 / count);
            end
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (i == count - 1 && $urandom_range(0, 3) == 0) v = 64'sd2147483647;
            load_entry(i[IDX_W-1:0], v[KEY_W-1:0]);
        end
    endtask

    // Searches right after reset see an empty table
    task automatic test_empty_table();
        search_for(32'sh8000_0000);
        search_for(32'sh7fff_ffff);
        search_for(32'sd0);
        drain_results();
    endtask

    // Small hand-made table: extremes, duplicates, misses, then an unsorted entry
    task automatic test_directed_table();
        load_entry(10'd0, 32'sh8000_0000);
        load_entry(10'd1, -32'sd5);
        load_entry(10'd2, 32'sd7);
        load_entry(10'd3, 32'sd7);
        load_entry(10'd4, 32'sd7);
        load_entry(10'd5, 32'sh7fff_ffff);
        load_entry(10'd1023, -32'sd1);
        drain_results();
        write_table_length(11'd6);
        search_for(32'sh8000_0000);
        search_for(-32'sd5);
        search_for(32'sd7);
        search_for(32'sh7fff_ffff);
        search_for(-32'sd6);
        search_for(32'sd0);
        search_for(32'sh7fff_fffe);
        search_for(-32'sd1);
        // break the order and search anyway
        load_entry(10'd2, 32'sh7fff_0000);
        search_for(-32'sd5);
        search_for(32'sd7);
        drain_results();
        write_table_length(11'd1);
        search_for(32'sh8000_0000);
        search_for(32'sd7);
        drain_results();
    endtask

    // Fill every entry, then search at full length and at a length past the depth
    task automatic test_full_table();
        load_sorted_run(TABLE_DEPTH);
        drain_results();
        write_table_length(11'd1024);
        search_for(entry_mirror[0]);
        search_for(entry_mirror[TABLE_DEPTH-1]);
        search_for(entry_mirror[TABLE_DEPTH/2]);
        search_for(32'sh8000_0000);
        search_for(32'sh7fff_ffff);
        for (int i = 0; i < 25; i++) search_for(pick_probe_key(TABLE_DEPTH));
        drain_results();
        write_table_length(11'd2047);
        for (int i = 0; i < 20; i++) search_for(pick_probe_key(TABLE_DEPTH));
        drain_results();
    endtask

    // Phases of random length: sorted fill, searches, some stray loads
    task automatic test_random_traffic();
        int target;
        int span;
        int roll;
        int count;
        target = loads_sent + searches_sent + 550;
        while (loads_sent + searches_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) span = 0;
            else if (roll < 75) span = $urandom_range(1, 32);
            else if (roll < 92) span = $urandom_range(33, 200);
            else if (roll < 97) span = $urandom_range(201, 1024);
            else span = $urandom_range(1025, 2047);
            write_table_length(span[LEN_W-1:0]);
            // every entry is written by now, so large lengths reuse old contents
            if (span > 0 && span <= 200) load_sorted_run(span);
            count = $urandom_range(8, 30);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 9) == 0) load_entry(IDX_W'($urandom), $urandom);
                else search_for(pick_probe_key(span));
            end
            drain_results();
        end
    endtask

    // Receiver stalls, switching among its own patterns
    always @(posedge aclk) begin
        if (mode_cycles == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_cycles = $urandom_range(50, 300);
        end
        mode_cycles--;
        pattern_step++;
        case (ready_mode)
            READY_ALWAYS:   m_tready <= 1'b1;
            READY_COIN:     m_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
            default:        m_tready <= ((pattern_step % 11) >= 7);
        endcase
    end

    // Compare each result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: result with nothing expected: found=%0b tdata=%0h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                oldest_lookup = pending_lookups.pop_front();
                results_checked++;
                if (oldest_lookup.found) hits_seen++;
                if (m_tuser !== oldest_lookup.found) begin
                    $display("%0t: found mismatch: expected %0b actual %0b",
                             $time, oldest_lookup.found, m_tuser);
                    error_count++;
                end
                if (m_tdata !== {{M_PAD_W{1'b0}}, oldest_lookup.position}) begin
                    $display("%0t: position mismatch: expected %0d actual %0d (tdata %0h)",
                             $time, oldest_lookup.position, m_tdata[IDX_W-1:0], m_tdata);
                    error_count++;
                end
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no request or result for %0d cycles, %0d results pending",
                     $time, idle_cycles, pending_lookups.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_directed_table();
        test_full_table();
        test_random_traffic();
        drain_results();
        if (pending_lookups.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_lookups.size());
            error_count++;
        end
        $display("Sent %0d loads and %0d searches; checked %0d results, %0d of them hits",
                 loads_sent, searches_sent, results_checked, hits_seen);
        $display("Table lengths ranged from empty to full and past the depth, with stalls");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
